>>> sv/bkpw_pkg.sv
// Package with shared constants and types for the box kernel particle weight unit.
`default_nettype none
package bkpw_pkg;
  localparam int unsigned MaxParticles = 1024;
  localparam int unsigned NumParams    = 8;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned IdxW         = $clog2(MaxParticles);
  localparam int unsigned CntW         = $clog2(MaxParticles + 1);
  localparam int unsigned ParamMemW    = DataW * NumParams;
  localparam int unsigned SumW         = 64;

  localparam logic [DataW-1:0] OneFix = DataW'(1) << FracBits;

  localparam logic [0:0] RegKernelFactor = 1'b0;
  localparam logic [0:0] RegFirstRound   = 1'b1;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef logic [DataW-1:0] word_t;
  typedef word_t [NumParams-1:0] param_vec_t;
endpackage
`default_nettype wire

>>> sv/bkpw_if.sv
// Valid/ready channel interfaces for input particles and result weights.
`default_nettype none
interface bkpw_in_if;
  import bkpw_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  logic  starts_set;
  word_t param_0, param_1, param_2, param_3, param_4, param_5, param_6, param_7;
  word_t prior_weight;
  modport source (output valid, kind, starts_set, param_0, param_1, param_2, param_3,
                  param_4, param_5, param_6, param_7, prior_weight, input ready);
  modport sink (input valid, kind, starts_set, param_0, param_1, param_2, param_3,
                param_4, param_5, param_6, param_7, prior_weight, output ready);
endinterface

interface bkpw_out_if;
  import bkpw_pkg::*;
  logic  valid;
  logic  ready;
  word_t new_weight;
  logic  no_neighbour;
  logic  saturated;
  modport source (output valid, new_weight, no_neighbour, saturated, input ready);
  modport sink (input valid, new_weight, no_neighbour, saturated, output ready);
endinterface
`default_nettype wire

>>> sv/bkpw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bkpw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/bkpw_recip.sv
// Restoring divider computing 2^(2*FracBits) / sum, one quotient bit per cycle.
`default_nettype none
module bkpw_recip import bkpw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] sum_i,
  output logic                 done_o,
  output logic [SumW-1:0]      quot_o
);
  localparam int unsigned NumW = 2 * FracBits + 1;
  localparam int unsigned BitW = $clog2(NumW + 1);
  localparam logic [NumW-1:0] Num = NumW'(1) << (2 * FracBits);

  logic [SumW-1:0] den_q, rem_q, quot_q;
  logic [BitW-1:0] bit_q;
  logic            busy_q, done_q;
  logic [SumW:0]   trial;
  logic [SumW-1:0] rem_sh;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    rem_sh = {rem_q[SumW-2:0], Num[bit_q - BitW'(1)]};
    trial  = {1'b0, rem_sh} - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= BitW'(NumW);
      end else if (busy_q) begin
        bit_q <= bit_q - BitW'(1);
        if (bit_q == BitW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= sum_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      if (!trial[SumW]) begin
        rem_q  <= trial[SumW-1:0];
        quot_q <= {quot_q[SumW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[SumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

>>> sv/box_kernel_particle_weight_unit.sv
// Top level of the box kernel particle weight unit.
//
//  Channel   Dir  Handshake      Beat contents
//  in_ch     in   valid/ready    kind, starts_set, param_0..7, prior_weight
//  out_ch    out  valid/ready    new_weight, no_neighbour, saturated
//  cfg       in   write enable   cfg_idx_i, cfg_data_i
//
// A load is stored as it is accepted. A query sets up the window
// one parameter at a time (one 32x32 multiply per parameter), then scans the
// particle memory (one read per cycle) and runs the bit-serial reciprocal
// divider. In the first round a query skips all three; an empty sum skips the divider.
// Reset clears the count, ranges and control; the memories need no clearing.
// One item is worked at a time; a result waits in the output register.
`default_nettype none
module box_kernel_particle_weight_unit import bkpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bkpw_in_if.sink          in_ch,
  bkpw_out_if.source       out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWin  = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam int unsigned PiW = (NumParams > 1) ? $clog2(NumParams) : 1;

  logic [2:0]      state_q;
  word_t           kfac_q;
  logic            first_q;
  logic [CntW-1:0] count_q;
  param_vec_t      lo_q, hi_q, query_q;
  logic [SumW-1:0] win_q [NumParams];
  logic [PiW-1:0]  wi_q;
  logic [CntW-1:0] rd_q;
  logic            hit_v_q;
  logic [SumW-1:0] sum_q;
  word_t           res_q;
  logic            nn_q, sat_q, ovalid_q;

  // Register writes; unknown indexes cannot occur with a one-bit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kfac_q  <= OneFix;
      first_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegKernelFactor) kfac_q <= cfg_data_i;
      if (cfg_idx_i == RegFirstRound)   first_q <= cfg_data_i[0];
    end
  end

  param_vec_t in_p;
  assign in_p = {in_ch.param_7, in_ch.param_6, in_ch.param_5, in_ch.param_4,
                 in_ch.param_3, in_ch.param_2, in_ch.param_1, in_ch.param_0};

  logic acc;
  assign in_ch.ready = (state_q == StIdle);
  assign acc = in_ch.valid && in_ch.ready;

  logic            is_load, do_store;
  logic [CntW-1:0] base_cnt;
  always_comb begin
    is_load  = acc && (in_ch.kind == KindLoad);
    base_cnt = in_ch.starts_set ? '0 : count_q;
    do_store = is_load && (base_cnt < CntW'(MaxParticles));
  end

  // Particle memories: parameters as one wide row, weights separately.
  logic [IdxW-1:0]      raddr;
  logic [ParamMemW-1:0] prow;
  word_t                wrow;
  assign raddr = rd_q[IdxW-1:0];

  bkpw_ram #(.Width(ParamMemW), .Depth(MaxParticles)) u_pmem (
    .clk_i, .we_i(do_store), .waddr_i(base_cnt[IdxW-1:0]), .wdata_i(in_p),
    .raddr_i(raddr), .rdata_o(prow));
  bkpw_ram #(.Width(DataW), .Depth(MaxParticles)) u_wmem (
    .clk_i, .we_i(do_store), .waddr_i(base_cnt[IdxW-1:0]),
    .wdata_i(in_ch.prior_weight), .raddr_i(raddr), .rdata_o(wrow));

  // Window of one parameter per cycle.
  word_t span;
  logic [SumW-1:0] prod;
  always_comb begin
    span = (hi_q[wi_q] >= lo_q[wi_q]) ? hi_q[wi_q] - lo_q[wi_q] : '0;
    prod = SumW'(kfac_q) * SumW'(span);
  end

  // Neighbour test against the row read last cycle.
  logic close;
  always_comb begin
    word_t sp, d;
    close = 1'b1;
    for (int i = 0; i < NumParams; i++) begin
      sp = prow[i*DataW +: DataW];
      d  = (query_q[i] >= sp) ? query_q[i] - sp : sp - query_q[i];
      if (SumW'(d) > win_q[i]) close = 1'b0;
    end
  end

  logic            div_start, div_done;
  logic [SumW-1:0] quot;
  bkpw_recip u_recip (.clk_i, .rst_ni, .start_i(div_start), .sum_i(sum_q),
                      .done_o(div_done), .quot_o(quot));

  logic [SumW-1:0] sum_next;
  assign sum_next = sum_q + ((hit_v_q && close) ? SumW'(wrow) : '0);
  assign div_start = (state_q == StScan) && !(rd_q < count_q) && !hit_v_q
                     && (sum_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      hit_v_q  <= 1'b0;
      for (int i = 0; i < NumParams; i++) begin
        lo_q[i] <= '1;
        hi_q[i] <= '0;
      end
    end else begin
      // The output state reloads the valid flag itself.
      if (out_ch.valid && out_ch.ready && state_q != StOut) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (is_load) begin
            // A set start always stores, so the ranges restart from this particle.
            if (do_store) begin
              count_q <= base_cnt + CntW'(1);
              for (int i = 0; i < NumParams; i++) begin
                if (in_ch.starts_set || in_p[i] < lo_q[i]) lo_q[i] <= in_p[i];
                if (in_ch.starts_set || in_p[i] > hi_q[i]) hi_q[i] <= in_p[i];
              end
            end
          end else if (acc) begin
            if (first_q) begin
              state_q <= StOut;
            end else begin
              state_q <= StWin;
            end
          end
        end
        StWin: begin
          if (wi_q == PiW'(NumParams - 1)) state_q <= StScan;
        end
        StScan: begin
          hit_v_q <= rd_q < count_q;
          if (!(rd_q < count_q) && !hit_v_q) begin
            state_q <= (sum_q == '0) ? StOut : StDiv;
          end
        end
        StDiv: begin
          if (div_done) state_q <= StOut;
        end
        StOut: begin
          if (!ovalid_q || out_ch.ready) begin
            ovalid_q <= 1'b1;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers of the query.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        query_q <= in_p;
        wi_q    <= '0;
        rd_q    <= '0;
        sum_q   <= '0;
        res_q   <= OneFix;
        nn_q    <= 1'b0;
        sat_q   <= 1'b0;
      end
      StWin: begin
        win_q[wi_q] <= prod >> FracBits;
        wi_q        <= wi_q + PiW'(1);
      end
      StScan: begin
        if (rd_q < count_q) rd_q <= rd_q + CntW'(1);
        sum_q <= sum_next;
        if (!(rd_q < count_q) && !hit_v_q && sum_q == '0) nn_q <= 1'b1;
      end
      StDiv: begin
        if (div_done) begin
          if (quot > SumW'(32'hFFFF_FFFF)) begin
            res_q <= '1;
            sat_q <= 1'b1;
          end else begin
            res_q <= quot[DataW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Output register, loaded once the previous result has left.
  word_t ow_q;
  logic  onn_q, osat_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!ovalid_q || out_ch.ready)) begin
      ow_q   <= res_q;
      onn_q  <= nn_q;
      osat_q <= sat_q;
    end
  end

  assign out_ch.valid        = ovalid_q;
  assign out_ch.new_weight   = ow_q;
  assign out_ch.no_neighbour = onn_q;
  assign out_ch.saturated    = osat_q;
endmodule
`default_nettype wire

>>> dv/box_kernel_particle_weight_unit_tb.sv
// Self-checking testbench for the box kernel particle weight unit.
module box_kernel_particle_weight_unit_tb;
  import bkpw_pkg::*;

  typedef struct packed {
    logic       kind;
    logic       starts_set;
    param_vec_t params;
    word_t      weight;
  } particle_t;

  typedef struct packed {
    word_t new_weight;
    logic  no_neighbour;
    logic  saturated;
  } weight_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = RegKernelFactor;
  logic [31:0] cfg_data = '0;

  bkpw_in_if  in_bus ();
  bkpw_out_if out_bus ();

  box_kernel_particle_weight_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Pending input beats and expected result weights.
  particle_t   pend_q[$];
  weight_res_t weight_q[$];
  int          err_cnt = 0;
  int          item_cnt = 0;
  bit          in_noisy = 1'b1;
  bit          out_noisy = 1'b1;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Shadow of the particle store, the ranges and the registers.
  word_t       set_params[MaxParticles][NumParams];
  word_t       set_weights[MaxParticles];
  int unsigned set_count;
  word_t       span_low[NumParams];
  word_t       span_high[NumParams];
  word_t       kf_shadow;
  logic        first_shadow;

  // Generator-side copy of the current set, used to aim queries at neighbors.
  param_vec_t  gen_set[$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic clear_ranges();
    set_count = 0;
    for (int i = 0; i < NumParams; i++) begin
      span_low[i] = '1;
      span_high[i] = '0;
    end
  endtask

  // Update the shadow store on a load; compute the weight on a query.
  task automatic apply_particle(input particle_t it);
    logic [63:0] win[NumParams];
    logic [63:0] total;
    logic [63:0] quot;
    word_t       span, d, a, b;
    bit          close;
    weight_res_t res;
    if (it.kind == KindLoad) begin
      if (it.starts_set) clear_ranges();
      if (set_count < MaxParticles) begin
        for (int i = 0; i < NumParams; i++) begin
          set_params[set_count][i] = it.params[i];
          if (it.params[i] < span_low[i]) span_low[i] = it.params[i];
          if (it.params[i] > span_high[i]) span_high[i] = it.params[i];
        end
        set_weights[set_count] = it.weight;
        set_count++;
      end
    end else begin
      res = '{new_weight: OneFix, no_neighbour: 1'b0, saturated: 1'b0};
      if (!first_shadow) begin
        total = '0;
        for (int i = 0; i < NumParams; i++) begin
          span = (span_high[i] >= span_low[i]) ? span_high[i] - span_low[i] : '0;
          win[i] = (64'(kf_shadow) * 64'(span)) >> FracBits;
        end
        for (int n = 0; n < set_count; n++) begin
          close = 1'b1;
          for (int i = 0; i < NumParams; i++) begin
            a = it.params[i];
            b = set_params[n][i];
            d = (a >= b) ? a - b : b - a;
            if (64'(d) > win[i]) close = 1'b0;
          end
          if (close) total += 64'(set_weights[n]);
        end
        if (total == 0) begin
          res.no_neighbour = 1'b1;
        end else begin
          quot = (64'd1 << (2 * FracBits)) / total;
          if (quot > 64'hFFFF_FFFF) begin
            res.new_weight = '1;
            res.saturated = 1'b1;
          end else begin
            res.new_weight = quot[31:0];
          end
        end
      end
      weight_q.insert(weight_q.size(), res);
    end
  endtask

  // Input driver: one beat per handshake, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (pend_q.size() != 0 && !(in_noisy && $urandom_range(99) < 29)) begin
        particle_t it;
        it = pend_q.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.kind         <= it.kind;
        in_bus.starts_set   <= it.starts_set;
        in_bus.param_0      <= it.params[0];
        in_bus.param_1      <= it.params[1];
        in_bus.param_2      <= it.params[2];
        in_bus.param_3      <= it.params[3];
        in_bus.param_4      <= it.params[4];
        in_bus.param_5      <= it.params[5];
        in_bus.param_6      <= it.params[6];
        in_bus.param_7      <= it.params[7];
        in_bus.prior_weight <= it.weight;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !(out_noisy && $urandom_range(99) < 29);
    end
  end

  // Monitor: predict on accepted input beats, check accepted result beats.
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      apply_particle('{kind: in_bus.kind, starts_set: in_bus.starts_set,
                       params: {in_bus.param_7, in_bus.param_6, in_bus.param_5,
                                in_bus.param_4, in_bus.param_3, in_bus.param_2,
                                in_bus.param_1, in_bus.param_0},
                       weight: in_bus.prior_weight});
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (weight_q.size() == 0) begin
        report("result beat with no expected weight");
      end else begin
        weight_res_t exp_res;
        exp_res = weight_q.pop_front();
        if (out_bus.new_weight !== exp_res.new_weight)
          report($sformatf("new_weight %h, expected %h", out_bus.new_weight,
                           exp_res.new_weight));
        if (out_bus.no_neighbour !== exp_res.no_neighbour)
          report($sformatf("no_neighbour %b, expected %b", out_bus.no_neighbour,
                           exp_res.no_neighbour));
        if (out_bus.saturated !== exp_res.saturated)
          report($sformatf("saturated %b, expected %b", out_bus.saturated,
                           exp_res.saturated));
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == RegKernelFactor) kf_shadow = val;
    else first_shadow = val[0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait until every beat is sent and every result has come, then let the block settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_bus.valid || weight_q.size() != 0);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic push_particle(input logic kind, input logic starts, input param_vec_t p,
                               input word_t w);
    pend_q.insert(pend_q.size(), '{kind: kind, starts_set: starts, params: p, weight: w});
    item_cnt++;
  endtask

  function automatic word_t rand_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return $urandom();
      default: return $urandom_range(32'h0003_0000, 32'h0000_0100);
    endcase
  endfunction

  // Load a set of n particles clustered around a random center, or spread at random when wide is set.
  task automatic load_set(input int n, input bit wide);
    param_vec_t center, p;
    int unsigned spread;
    for (int i = 0; i < NumParams; i++) center[i] = $urandom();
    spread = $urandom_range(20, 4);
    gen_set.delete();
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < NumParams; i++)
        p[i] = wide ? word_t'($urandom()) : center[i] + ($urandom() >> spread);
      gen_set.insert(gen_set.size(), p);
      push_particle(KindLoad, k == 0, p, rand_weight());
    end
  endtask

  // Queries: mostly exact or nudged copies of stored particles, some random.
  task automatic query_set(input int n);
    param_vec_t p;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(3);
      if (gen_set.size() == 0 || pick == 3) begin
        for (int i = 0; i < NumParams; i++) p[i] = $urandom();
      end else begin
        p = gen_set[$urandom_range(gen_set.size() - 1)];
        if (pick != 0)
          for (int i = 0; i < NumParams; i++)
            p[i] = p[i] + ($urandom() >> $urandom_range(31, 12)) -
                   ($urandom() >> $urandom_range(31, 12));
      end
      push_particle(KindQuery, 1'($urandom_range(1)), p, $urandom());
    end
  endtask

  initial begin
    param_vec_t  zeros, ones, mid;
    word_t       kf_pick;
    in_bus.valid = 1'b0;
    in_bus.kind = KindLoad;
    in_bus.starts_set = 1'b0;
    in_bus.param_0 = '0; in_bus.param_1 = '0; in_bus.param_2 = '0; in_bus.param_3 = '0;
    in_bus.param_4 = '0; in_bus.param_5 = '0; in_bus.param_6 = '0; in_bus.param_7 = '0;
    in_bus.prior_weight = '0;
    out_bus.ready = 1'b0;
    kf_shadow = 32'd65536;
    first_shadow = 1'b1;
    clear_ranges();
    zeros = '0;
    ones = '1;
    for (int i = 0; i < NumParams; i++) mid[i] = 32'h8000_0000 >> i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first round, empty store, extreme particles and weights.
    push_particle(KindQuery, 1'b0, mid, '1);
    wait_idle();
    write_reg(RegFirstRound, 32'd0);
    push_particle(KindQuery, 1'b0, zeros, '0);
    push_particle(KindLoad, 1'b1, zeros, 32'd1);
    push_particle(KindQuery, 1'b0, zeros, '0);
    push_particle(KindQuery, 1'b0, ones, '0);
    push_particle(KindLoad, 1'b0, ones, '1);
    push_particle(KindQuery, 1'b0, zeros, '0);
    push_particle(KindQuery, 1'b0, mid, '0);
    push_particle(KindLoad, 1'b0, mid, '0);
    push_particle(KindQuery, 1'b1, mid, '1);
    push_particle(KindLoad, 1'b1, mid, '0);
    push_particle(KindQuery, 1'b0, mid, '0);
    push_particle(KindLoad, 1'b0, ones, 32'h0001_0000);
    push_particle(KindQuery, 1'b0, ones, '0);
    wait_idle();
    write_reg(RegKernelFactor, 32'd0);
    push_particle(KindQuery, 1'b0, ones, '0);
    push_particle(KindQuery, 1'b0, mid, '0);
    wait_idle();
    write_reg(RegKernelFactor, '1);
    push_particle(KindQuery, 1'b0, zeros, '0);
    push_particle(KindQuery, 1'b0, mid, '0);
    wait_idle();

    // Random phases over several register settings.
    for (int ph = 0; item_cnt < 580; ph++) begin
      case (ph % 6)
        0: kf_pick = 32'd0;
        1: kf_pick = 32'd65536;
        2: kf_pick = '1;
        3: kf_pick = $urandom_range(32'h0000_2000, 32'h0000_0001);
        default: kf_pick = $urandom();
      endcase
      write_reg(RegKernelFactor, kf_pick);
      write_reg(RegFirstRound, 32'(ph % 9 == 4));
      in_noisy = ph % 7 != 3;
      out_noisy = ph % 7 != 3;
      if (ph % 5 == 2) query_set(1);
      load_set($urandom_range(24, 1), ph % 4 == 1);
      query_set($urandom_range(10, 4));
      if (ph == 5) hold_req++;
      wait_idle();
    end

    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> filelist.f
sv/bkpw_pkg.sv
sv/bkpw_if.sv
sv/bkpw_ram.sv
sv/bkpw_recip.sv
sv/box_kernel_particle_weight_unit.sv
dv/box_kernel_particle_weight_unit_tb.sv
